FILE: src/tpc_pkg.sv
// shared constants for the three point curvature block
package tpc_pkg;

	// inverse length result width, unsigned q16
	localparam int INV_BITS = 17;
	// inverse length limit is 2^32 on q*q*d
	localparam int SQRT_LIM_EXP = 32;
	// result field width
	localparam int OUT_BITS = 27;
	// result tdata width padded to bytes
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	// final shift of the double product (2*x >> 24 == x >> 23)
	localparam int FRAC_SHIFT = 23;

endpackage

FILE: src/tpc_front.sv
// front stage: midpoint, squared side lengths and cross product of one word
module tpc_front #(
	parameter int ROW_BITS = 7,
	parameter int COL_BITS = 8,
	parameter int DW = 2 * ((ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS) + 1,
	parameter int MW = ROW_BITS + COL_BITS + 2,
	parameter int IW = 3 * DW + MW + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROW_BITS-1:0] start_row,
	input  logic [ROW_BITS-1:0] row_end,
	input  logic [COL_BITS-1:0] col_at_start,
	input  logic [COL_BITS-1:0] col_at_middle,
	input  logic [COL_BITS-1:0] col_at_end,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [IW-1:0]       out_item
);
	localparam int XW = ROW_BITS + COL_BITS + 3;

	logic                         v_q;
	logic [IW-1:0]                item_q;
	logic [ROW_BITS:0]            sum_r;
	logic [ROW_BITS-1:0]          rm;
	logic signed [ROW_BITS:0]     dr1, dr2, dr3;
	logic signed [COL_BITS:0]     dc1, dc2, dc3;
	logic signed [2*ROW_BITS+1:0] sr1, sr2, sr3;
	logic signed [2*COL_BITS+1:0] sc1, sc2, sc3;
	logic [DW-1:0]                d1, d2, d3;
	logic signed [ROW_BITS+COL_BITS+1:0] t1, t2;
	logic signed [XW-1:0]         area2;
	logic [MW-1:0]                mag;
	logic                         neg, degen;

	// point differences
	always_comb begin
		sum_r = {1'b0, start_row} + {1'b0, row_end};
		rm    = sum_r[ROW_BITS:1];
		dr1   = $signed({1'b0, start_row}) - $signed({1'b0, rm});
		dr2   = $signed({1'b0, row_end}) - $signed({1'b0, rm});
		dr3   = $signed({1'b0, row_end}) - $signed({1'b0, start_row});
		dc1   = $signed({1'b0, col_at_start}) - $signed({1'b0, col_at_middle});
		dc2   = $signed({1'b0, col_at_end}) - $signed({1'b0, col_at_middle});
		dc3   = $signed({1'b0, col_at_end}) - $signed({1'b0, col_at_start});
	end

	// squared lengths and twice the signed area
	always_comb begin
		sr1   = dr1 * dr1;
		sr2   = dr2 * dr2;
		sr3   = dr3 * dr3;
		sc1   = dc1 * dc1;
		sc2   = dc2 * dc2;
		sc3   = dc3 * dc3;
		d1    = DW'(sr1[2*ROW_BITS:0]) + DW'(sc1[2*COL_BITS:0]);
		d2    = DW'(sr2[2*ROW_BITS:0]) + DW'(sc2[2*COL_BITS:0]);
		d3    = DW'(sr3[2*ROW_BITS:0]) + DW'(sc3[2*COL_BITS:0]);
		t1    = dc1 * (-dr3);
		t2    = dr1 * dc3;
		area2 = XW'(t1) + XW'(t2);
		neg   = area2[XW-1];
		mag   = neg ? MW'(-area2) : MW'(area2);
		degen = (d1 == '0) || (d2 == '0) || (d3 == '0);
	end

	assign in_ready  = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_item  = item_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= {degen, neg, mag, d3, d2, d1};
		end
	end

endmodule

FILE: src/tpc_queue.sv
// two-entry queue between front and back
module tpc_queue #(
	parameter int IW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [IW-1:0] in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [IW-1:0] out_item
);
	logic [IW-1:0] slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_item  = slot_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= in_item;
		end
	end

endmodule

FILE: src/tpc_back.sv
// back pipeline: three inverse square roots then the scaled product
module tpc_back #(
	parameter int ROW_BITS = 7,
	parameter int COL_BITS = 8,
	parameter int DW = 2 * ((ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS) + 1,
	parameter int MW = ROW_BITS + COL_BITS + 2,
	parameter int IW = 3 * DW + MW + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [IW-1:0]                 in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tpc_pkg::OUT_BITS-1:0]  curvature_q24,
	output logic                          degenerate
);
	import tpc_pkg::*;

	localparam int NST = INV_BITS;
	localparam int CW  = DW + SQRT_LIM_EXP + 4;
	localparam int P1W = MW + INV_BITS;
	localparam int L1  = P1W / 2;
	localparam int H1  = P1W - L1;
	localparam int P2W = P1W + INV_BITS;
	localparam int L2  = P2W / 2;
	localparam int H2  = P2W - L2;
	localparam int P3W = P2W + INV_BITS;
	localparam int QW  = P3W - FRAC_SHIFT;

	logic                en;
	logic                v_is [NST+1];
	logic [DW-1:0]       d_s [NST+1][3];
	logic [CW-1:0]       p_s [NST+1][3];
	logic [CW-1:0]       qd_s [NST+1][3];
	logic [INV_BITS-1:0] inv_s [NST+1][3];
	logic [MW-1:0]       mag_s [NST+1];
	logic                neg_s [NST+1];
	logic                dg_s [NST+1];

	logic                 v_m1, v_m2, v_m3, v_m4;
	logic [P1W-1:0]       p1_m1;
	logic [INV_BITS-1:0]  i2_m1, i3_m1, i3_m2, i3_m3;
	logic [L1+INV_BITS-1:0] pl_m2;
	logic [H1+INV_BITS-1:0] ph_m2;
	logic [P2W-1:0]       p2_m3;
	logic [L2+INV_BITS-1:0] pl_m4;
	logic [H2+INV_BITS-1:0] ph_m4;
	logic                 neg_m1, neg_m2, neg_m3, neg_m4;
	logic                 dg_m1, dg_m2, dg_m3, dg_m4;
	logic [P3W-1:0]       p3;
	logic [QW-1:0]        qv;
	logic                 rem;
	logic [QW:0]          qsum;
	logic [OUT_BITS-1:0]  qmag, res;
	logic                 out_v_q;
	logic [OUT_BITS-1:0]  curv_q;
	logic                 dg_q;

	// whole pipeline moves when the output register frees up
	assign en        = !out_v_q || out_ready;
	assign in_ready  = en;
	assign out_valid = out_v_q;
	assign curvature_q24 = curv_q;
	assign degenerate    = dg_q;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NST; j++) v_is[j] <= 1'b0;
			v_m1    <= 1'b0;
			v_m2    <= 1'b0;
			v_m3    <= 1'b0;
			v_m4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_is[0] <= in_valid;
			for (int j = 1; j <= NST; j++) v_is[j] <= v_is[j-1];
			v_m1    <= v_is[NST];
			v_m2    <= v_m1;
			v_m3    <= v_m2;
			v_m4    <= v_m3;
			out_v_q <= v_m4;
		end
	end

	// entry stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				d_s[0][l]   <= in_item[l*DW +: DW];
				p_s[0][l]   <= '0;
				qd_s[0][l]  <= '0;
				inv_s[0][l] <= '0;
			end
			mag_s[0] <= in_item[3*DW +: MW];
			neg_s[0] <= in_item[3*DW+MW];
			dg_s[0]  <= in_item[3*DW+MW+1];
		end
	end

	// inverse length, one result bit per stage, kept as q*q*d and q*d
	for (genvar j = 1; j <= NST; j++) begin : g_isq
		localparam int K = NST - j;
		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [CW-1:0] cand;
			assign cand = p_s[j-1][l] + (qd_s[j-1][l] << (K + 1))
				+ (CW'(d_s[j-1][l]) << (2 * K));
			always_ff @(posedge clk) begin
				if (en) begin
					d_s[j][l] <= d_s[j-1][l];
					if (cand <= (CW'(1) << SQRT_LIM_EXP)) begin
						p_s[j][l]   <= cand;
						qd_s[j][l]  <= qd_s[j-1][l] + (CW'(d_s[j-1][l]) << K);
						inv_s[j][l] <= inv_s[j-1][l] | (INV_BITS'(1) << K);
					end else begin
						p_s[j][l]   <= p_s[j-1][l];
						qd_s[j][l]  <= qd_s[j-1][l];
						inv_s[j][l] <= inv_s[j-1][l];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s[j] <= mag_s[j-1];
				neg_s[j] <= neg_s[j-1];
				dg_s[j]  <= dg_s[j-1];
			end
		end
	end

	// final rounding toward minus infinity
	always_comb begin
		p3   = (P3W'(ph_m4) << L2) + P3W'(pl_m4);
		qv   = p3[P3W-1:FRAC_SHIFT];
		rem  = |p3[FRAC_SHIFT-1:0];
		qsum = {1'b0, qv} + (QW+1)'(neg_m4 && rem);
		qmag = qsum[OUT_BITS-1:0];
		res  = neg_m4 ? -qmag : qmag;
	end

	// product stages
	always_ff @(posedge clk) begin
		if (en) begin
			p1_m1  <= P1W'(mag_s[NST]) * P1W'(inv_s[NST][0]);
			i2_m1  <= inv_s[NST][1];
			i3_m1  <= inv_s[NST][2];
			neg_m1 <= neg_s[NST];
			dg_m1  <= dg_s[NST];

			pl_m2  <= (L1+INV_BITS)'(p1_m1[L1-1:0]) * (L1+INV_BITS)'(i2_m1);
			ph_m2  <= (H1+INV_BITS)'(p1_m1[P1W-1:L1]) * (H1+INV_BITS)'(i2_m1);
			i3_m2  <= i3_m1;
			neg_m2 <= neg_m1;
			dg_m2  <= dg_m1;

			p2_m3  <= (P2W'(ph_m2) << L1) + P2W'(pl_m2);
			i3_m3  <= i3_m2;
			neg_m3 <= neg_m2;
			dg_m3  <= dg_m2;

			pl_m4  <= (L2+INV_BITS)'(p2_m3[L2-1:0]) * (L2+INV_BITS)'(i3_m3);
			ph_m4  <= (H2+INV_BITS)'(p2_m3[P2W-1:L2]) * (H2+INV_BITS)'(i3_m3);
			neg_m4 <= neg_m3;
			dg_m4  <= dg_m3;

			curv_q <= dg_m4 ? '0 : res;
			dg_q   <= dg_m4;
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && dg_q |-> curv_q == '0)
		else $error("degenerate word with nonzero curvature");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ($signed(curv_q) <= 27'sd33554432 && $signed(curv_q) >= -27'sd33554432))
		else $error("curvature out of range");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_m4 |=> out_v_q)
		else $error("pipeline word lost at output");

endmodule

FILE: src/three_point_curvature.sv
// Signed Menger curvature of three midline points, Q24 result.
// One word is accepted per cycle unless the output stalls. A word passes
// one front register, the queue, the bit-per-stage inverse square root
// stages for the three sides and five product stages. A full output
// register with m_axis_tready low stalls the back pipeline; the two-entry
// queue then absorbs the front until it fills.
module three_point_curvature #(
	parameter int ROW_BITS = 7,
	parameter int COL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// start_row, row_end, col_at_start, col_at_middle, col_at_end, zero pad
	input  logic [((2*ROW_BITS+3*COL_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// curvature_q24, zero pad
	output logic [tpc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// degenerate
	output logic [0:0]                           m_axis_tuser
);
	import tpc_pkg::*;

	localparam int DW = 2 * ((ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS) + 1;
	localparam int MW = ROW_BITS + COL_BITS + 2;
	localparam int IW = 3 * DW + MW + 2;

	logic          f_valid, f_ready, b_valid, b_ready;
	logic [IW-1:0] f_item, b_item;
	logic [OUT_BITS-1:0] curv;
	logic          degen;

	// front: classify and precompute
	tpc_front #(.ROW_BITS(ROW_BITS), .COL_BITS(COL_BITS), .DW(DW), .MW(MW), .IW(IW))
	u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.start_row(s_axis_tdata[ROW_BITS-1:0]),
		.row_end(s_axis_tdata[2*ROW_BITS-1:ROW_BITS]),
		.col_at_start(s_axis_tdata[2*ROW_BITS +: COL_BITS]),
		.col_at_middle(s_axis_tdata[2*ROW_BITS+COL_BITS +: COL_BITS]),
		.col_at_end(s_axis_tdata[2*ROW_BITS+2*COL_BITS +: COL_BITS]),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	// decoupling queue
	tpc_queue #(.IW(IW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
	);

	// back: inverse lengths and product
	tpc_back #(.ROW_BITS(ROW_BITS), .COL_BITS(COL_BITS), .DW(DW), .MW(MW), .IW(IW))
	u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.curvature_q24(curv), .degenerate(degen)
	);

	assign m_axis_tdata = OUT_TDATA_W'(curv);
	assign m_axis_tuser = degen;

endmodule
